### src/plpl_pkg.sv
// Package for the phase lock pull loop: field widths, register codes, loop constants
// and the structs shared by the configuration block, the wrap unit and the top level.
// Depends on nothing.
package plpl_pkg;

  localparam int PERIOD_W = 24;
  localparam int TIME_W   = 48;
  localparam int ERR_W    = 48;
  localparam int PULL_W   = 26;
  localparam int AVG_W    = 25;
  localparam int OPER_W   = 49;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [1:0] REG_COMB_PERIOD = 2'd0;
  localparam logic [1:0] REG_SLEW_LIMIT  = 2'd1;
  localparam logic [1:0] REG_STALL_SPAN  = 2'd2;

  localparam logic [23:0] COMB_PERIOD_RESET = 24'd166667;
  localparam logic [23:0] SLEW_LIMIT_RESET  = 24'd1000;
  localparam logic [31:0] STALL_SPAN_RESET  = 32'd0;

  localparam logic [7:0] STALL_RUN_MIN    = 8'd3;
  localparam logic [7:0] STALL_SAT        = 8'd255;
  localparam logic [4:0] RECOVER_PRESENTS = 5'd16;

  localparam logic [5:0] WIDE_STEPS   = 6'd50;
  localparam logic [5:0] NARROW_STEPS = 6'd28;

  typedef struct packed {
    logic                     has_before;
    logic                     has_after;
    logic [TIME_W-1:0]        before_time;
    logic [TIME_W-1:0]        after_time;
    logic signed [ERR_W-1:0]  phase_error;
  } item_t;

  typedef struct packed {
    logic signed [PULL_W-1:0] pull_offset;
    logic                     locked;
    logic                     resumed;
    logic signed [23:0]       error_average;
    logic [23:0]              deviation_average;
    logic                     stalled;
  } result_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] comb_period;
    logic [23:0]         slew_limit;
    logic [31:0]         stall_span_limit;
  } cfg_t;

  typedef struct packed {
    logic                     start;
    logic                     narrow;
    logic signed [OPER_W-1:0] operand;
  } mod_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [AVG_W-1:0] wrapped;
  } mod_rsp_t;

endpackage

### src/plpl_cfg_regs.sv
// Configuration registers of the phase lock pull loop behind an APB-style port.
// Depends on plpl_pkg for the register codes, reset values and the cfg_t struct.
module plpl_cfg_regs import plpl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] index;
  logic       write_en;

  assign index    = paddr[3:2];
  assign pready   = 1'b1;
  assign write_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.comb_period      <= COMB_PERIOD_RESET;
      cfg.slew_limit       <= SLEW_LIMIT_RESET;
      cfg.stall_span_limit <= STALL_SPAN_RESET;
    end else if (write_en) begin
      unique case (index)
        REG_COMB_PERIOD: cfg.comb_period      <= pwdata[23:0];
        REG_SLEW_LIMIT:  cfg.slew_limit       <= pwdata[23:0];
        REG_STALL_SPAN:  cfg.stall_span_limit <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_COMB_PERIOD: prdata = {8'd0, cfg.comb_period};
      REG_SLEW_LIMIT:  prdata = {8'd0, cfg.slew_limit};
      REG_STALL_SPAN:  prdata = cfg.stall_span_limit;
      default:         prdata = '0;
    endcase
  end

endmodule

### src/plpl_wrap_unit.sv
// Shared serial wrap unit: folds a signed operand into [-floor(P/2), P - floor(P/2))
// of the comb period P with a restoring remainder, one operand bit per cycle.
// Depends on plpl_pkg for the request and response structs.
module plpl_wrap_unit import plpl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [PERIOD_W-1:0] period,
  input  mod_req_t            req,
  output mod_rsp_t            rsp
);

  logic [22:0]          half;
  logic signed [49:0]   biased;
  logic [49:0]          mag;
  logic [24:0]          rem_shift;
  logic [24:0]          rem_step;
  logic [23:0]          mod_val;
  logic signed [24:0]   wrapped_next;

  logic                 busy;
  logic [5:0]           cnt;
  logic [49:0]          sh;
  logic [23:0]          rem;
  logic                 neg;

  assign half      = period[23:1];
  assign biased    = 50'(req.operand) + $signed({27'd0, half});
  assign mag       = biased[49] ? (~biased + 50'd1) : biased;
  assign rem_shift = {rem, sh[49]};
  assign rem_step  = (rem_shift >= {1'b0, period}) ? (rem_shift - {1'b0, period}) : rem_shift;
  assign mod_val   = (neg && rem != 24'd0) ? (period - rem) : rem;
  assign wrapped_next = $signed({1'b0, mod_val}) - $signed({2'b0, half});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.narrow ? NARROW_STEPS : WIDE_STEPS;
      end else if (busy) begin
        if (cnt != 6'd0) begin
          cnt <= cnt - 6'd1;
        end else begin
          busy        <= 1'b0;
          rsp.done    <= 1'b1;
          rsp.wrapped <= wrapped_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sh  <= req.narrow ? {mag[27:0], 22'd0} : mag;
      rem <= '0;
      neg <= biased[49];
    end else if (busy) begin
      if (cnt != 6'd0) begin
        rem <= rem_step[23:0];
        sh  <= {sh[48:0], 1'b0};
      end
    end
  end

endmodule

### src/phase_lock_pull_loop.sv
// Top level of the phase lock pull loop: input and result channels, the loop sequencer
// and its state, the configuration block and the shared wrap unit.
// Depends on plpl_pkg, plpl_cfg_regs and plpl_wrap_unit.
//
// Usage: one item per display present arrives on item/item_valid and is taken in a
// transfer when item_stall is low. The block works on one item at a time and holds
// item_stall high until that item's result is in the output register.
// A stalled bracket (a frame missing, or its span above a nonzero stall_span_limit)
// gives its result from the check state once the output register is free. A tracked
// bracket runs four passes through the serial wrap unit, one operand bit per cycle
// (50 bits for the raw phase error, 28 for the later ones); the first tracked bracket
// and one that ends a run of at least three stalled brackets skip two passes. The lock,
// pull and wrap states follow, and the wrap state loads the result once the output
// register is free. A new item is accepted while a result still waits in the output
// register; the block holds its next result until that one is taken. When
// result_valid and result_stall are both high, result_valid and result stay as they
// are. Reset clears the loop state, the stall counter and result_valid, and loads the
// register reset values. The user writes registers through the APB port only while
// idle; the block itself does not enforce this.
module phase_lock_pull_loop import plpl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_ERR   = 4'd2;
  localparam logic [3:0] S_STEP  = 4'd3;
  localparam logic [3:0] S_AVG   = 4'd4;
  localparam logic [3:0] S_DEV   = 4'd5;
  localparam logic [3:0] S_LOCK  = 4'd6;
  localparam logic [3:0] S_PULL  = 4'd7;
  localparam logic [3:0] S_WRAP  = 4'd8;

  cfg_t     cfg;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  logic [3:0]               state;
  item_t                    item_r;
  logic                     seeded;
  logic signed [AVG_W-1:0]  err_avg;
  logic [23:0]              dev_avg;
  logic                     lock_flag;
  logic signed [PULL_W-1:0] pull;
  logic [4:0]               recover_left;
  logic [7:0]               stall_count;
  logic                     resumed_r;
  logic signed [AVG_W-1:0]  err_r;
  logic signed [26:0]       delta_r;

  logic [PERIOD_W-1:0]      p_eff;
  logic [48:0]              span;
  logic                     stall_now;
  logic                     out_free;
  logic                     out_load;
  logic                     wrap_start;
  logic                     recovering;
  logic signed [25:0]       step_biased;
  logic signed [25:0]       step_t;
  logic [24:0]              dev_mag;
  logic [28:0]              dev_sum;
  logic [23:0]              dev_avg_next;
  logic                     lock_next;
  logic signed [26:0]       delta_raw;
  logic [23:0]              slew;
  logic signed [26:0]       slew_s;
  logic signed [26:0]       delta_clamped;
  logic signed [27:0]       pull_sum;
  logic signed [27:0]       band;
  logic signed [27:0]       p_s;
  logic signed [27:0]       pull_wrapped;

  plpl_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  plpl_wrap_unit u_wrap (
    .clk    (clk),
    .rst    (rst),
    .period (p_eff),
    .req    (mod_req),
    .rsp    (mod_rsp)
  );

  assign p_eff      = (cfg.comb_period == '0) ? 24'd1 : cfg.comb_period;
  assign span       = {1'b0, item_r.after_time} - {1'b0, item_r.before_time};
  assign stall_now  = !item_r.has_before || !item_r.has_after ||
                      (cfg.stall_span_limit != 32'd0 &&
                       $signed(span) > $signed({17'd0, cfg.stall_span_limit}));
  assign out_free   = !result_valid || !result_stall;
  assign out_load   = (state == S_CHECK && stall_now && out_free) ||
                      (state == S_WRAP && out_free);
  assign wrap_start = (state == S_CHECK && !stall_now) ||
                      ((state == S_ERR || state == S_STEP || state == S_AVG) &&
                       mod_rsp.done);
  assign recovering = recover_left != 5'd0;
  assign item_stall = state != S_IDLE;

  assign step_biased = 26'(mod_rsp.wrapped) +
                       (mod_rsp.wrapped[AVG_W-1] ? (recovering ? 26'sd1 : 26'sd15) : 26'sd0);
  assign step_t      = recovering ? (step_biased >>> 1) : (step_biased >>> 4);

  assign dev_mag      = mod_rsp.wrapped[AVG_W-1] ? (~mod_rsp.wrapped + 25'd1) : mod_rsp.wrapped;
  assign dev_sum      = {1'b0, dev_avg, 4'd0} - {5'd0, dev_avg} + {5'd0, dev_mag[23:0]};
  assign dev_avg_next = dev_sum[27:4];
  assign lock_next    = dev_avg < {3'd0, p_eff[23:3]};

  assign delta_raw     = lock_flag ? 27'(err_avg) : -27'(pull);
  assign slew          = recovering ? {5'd0, p_eff[23:5]} : cfg.slew_limit;
  assign slew_s        = $signed({3'd0, slew});
  assign delta_clamped = (resumed_r && lock_flag) ? delta_raw :
                         (delta_raw > slew_s) ? slew_s :
                         (delta_raw < -slew_s) ? -slew_s : delta_raw;

  assign pull_sum     = 28'(pull) + 28'(delta_r);
  assign band         = $signed({8'd0, p_eff[23:4]});
  assign p_s          = $signed({4'd0, p_eff});
  assign pull_wrapped = (pull_sum < -band) ? (pull_sum + p_s) :
                        (pull_sum >= p_s + band) ? (pull_sum - p_s) : pull_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seeded        <= 1'b0;
      err_avg       <= '0;
      dev_avg       <= '0;
      lock_flag     <= 1'b0;
      pull          <= '0;
      recover_left  <= '0;
      stall_count   <= '0;
      resumed_r     <= 1'b0;
      result_valid  <= 1'b0;
      mod_req.start <= 1'b0;
    end else begin
      mod_req.start <= wrap_start;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stall_now) begin
            if (out_free) begin
              if (stall_count != STALL_SAT) begin
                stall_count <= stall_count + 8'd1;
              end
              state <= S_IDLE;
            end
          end else begin
            resumed_r       <= stall_count >= STALL_RUN_MIN;
            stall_count     <= '0;
            mod_req.narrow  <= 1'b0;
            mod_req.operand <= 49'(item_r.phase_error);
            state           <= S_ERR;
          end
        end
        S_ERR: begin
          if (mod_rsp.done) begin
            mod_req.narrow <= 1'b1;
            if (!seeded || resumed_r) begin
              err_avg         <= mod_rsp.wrapped;
              seeded          <= 1'b1;
              mod_req.operand <= '0;
              if (resumed_r) begin
                recover_left <= RECOVER_PRESENTS;
              end
              state <= S_DEV;
            end else begin
              mod_req.operand <= 49'(mod_rsp.wrapped) - 49'(err_avg);
              state           <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (mod_rsp.done) begin
            mod_req.narrow  <= 1'b1;
            mod_req.operand <= 49'(err_avg) + 49'(step_t);
            state           <= S_AVG;
          end
        end
        S_AVG: begin
          if (mod_rsp.done) begin
            err_avg         <= mod_rsp.wrapped;
            mod_req.narrow  <= 1'b1;
            mod_req.operand <= 49'(err_r) - 49'(mod_rsp.wrapped);
            state           <= S_DEV;
          end
        end
        S_DEV: begin
          if (mod_rsp.done) begin
            dev_avg <= dev_avg_next;
            state   <= S_LOCK;
          end
        end
        S_LOCK: begin
          lock_flag <= lock_next;
          state     <= S_PULL;
        end
        S_PULL: begin
          if (recovering) begin
            recover_left <= recover_left - 5'd1;
          end
          state <= S_WRAP;
        end
        S_WRAP: begin
          if (out_free) begin
            pull  <= pull_wrapped[PULL_W-1:0];
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      item_r <= item;
    end
    if (state == S_ERR && mod_rsp.done) begin
      err_r <= mod_rsp.wrapped;
    end
    if (state == S_PULL) begin
      delta_r <= delta_clamped;
    end
    if (state == S_CHECK && stall_now && out_free) begin
      result.pull_offset       <= pull;
      result.locked            <= lock_flag;
      result.resumed           <= 1'b0;
      result.error_average     <= err_avg[23:0];
      result.deviation_average <= dev_avg;
      result.stalled           <= 1'b1;
    end else if (state == S_WRAP && out_free) begin
      result.pull_offset       <= pull_wrapped[PULL_W-1:0];
      result.locked            <= lock_flag;
      result.resumed           <= resumed_r;
      result.error_average     <= err_avg[23:0];
      result.deviation_average <= dev_avg;
      result.stalled           <= 1'b0;
    end
  end

  a_stall_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && stall_now && out_free) |=>
      (result_valid && result.stalled && !result.resumed))
    else $error("stalled bracket did not give a held result");

  a_stall_sat: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && stall_now && out_free && stall_count == STALL_SAT) |=>
      (stall_count == STALL_SAT))
    else $error("stall counter wrapped past saturation");

  a_wrap_done: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |->
      (state == S_ERR || state == S_STEP || state == S_AVG || state == S_DEV))
    else $error("wrap unit finished outside a waiting state");

  a_tracked_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRAP && out_free) |=>
      (result_valid && !result.stalled && stall_count == 8'd0))
    else $error("tracked bracket result malformed");

endmodule
